### design/u8dec_pkg.sv
// Package with constants and types for the UTF-8 stream decoder.
package u8dec_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned TDATA_W = 24;

    localparam logic [CP_W-1:0]  REPL_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0]  SUR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0]  SUR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0]  MAX_TWO   = 21'h0007FF;
    localparam logic [CP_W-1:0]  MAX_THREE = 21'h00FFFF;
    localparam logic [CP_W-1:0]  MAX_UNI   = 21'h10FFFF;
    localparam logic [CP_W-1:0]  MIN_TWO   = 21'h000080;
    localparam logic [CNT_W-1:0] CNT_SAT   = 16'hFFFF;

    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last_of_run;
    } result_t;

endpackage

### design/utf8_stream_decoder.sv
// UTF-8 stream decoder: bytes in, Unicode code points out with error replacement.
//
// Input channel s_axis_*: one byte of a zero-terminated UTF-8 string per word.
// Output channel m_axis_*: one decoded code point per word; tuser marks a
// replacement (U+FFFD) for a malformed sequence, tlast marks the final result
// caused by one input byte. A byte gives zero, one or two results.
// Configuration: cfg_we writes cfg_wdata into the per-string result limit
// (0 = unlimited); write it only while the block is idle.
// Datapath: a byte is held in the input register, is decoded in one pass and
// lands in a two-word result queue, whose head drives m_axis_*. Throughput is
// one byte per cycle while each byte gives at most one result and the receiver
// keeps up; a byte that gives two results waits until the result queue is empty.
// Reset clears the decode state, the limit, the input register and the queue.
// When the receiver stalls the queue fills, the input register holds its byte
// and s_axis_tready drops; no result is lost or repeated.
module utf8_stream_decoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [u8dec_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] data_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [u8dec_pkg::TDATA_W-1:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic                               m_axis_tuser,   // [0] is_error
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [u8dec_pkg::CNT_W-1:0]        cfg_wdata
);

    logic                             in_valid_reg;
    logic [u8dec_pkg::BYTE_W-1:0]     in_byte_reg;
    logic [u8dec_pkg::CNT_W-1:0]      limit_reg;
    logic [u8dec_pkg::LEN_W-1:0]      seq_len_reg, seq_len_next;
    logic [u8dec_pkg::LEN_W-1:0]      seen_reg, seen_next;
    logic [u8dec_pkg::CP_W-1:0]       partial_reg, partial_next;
    logic [u8dec_pkg::CNT_W-1:0]      emitted_reg, emitted_next;
    logic                             lim_hit_reg, lim_hit_next;
    logic                             q0_valid_reg, q0_valid_next;
    logic                             q1_valid_reg, q1_valid_next;
    u8dec_pkg::result_t               q0_reg, q0_next;
    u8dec_pkg::result_t               q1_reg, q1_next;

    logic [7:0]                       b;
    logic                             lead_ascii;
    logic                             lead_bad;
    logic                             is_cont;
    logic [u8dec_pkg::CP_W-1:0]       acc;
    logic [u8dec_pkg::LEN_W-1:0]      seen_inc;
    logic                             seq_ok;
    logic [u8dec_pkg::CNT_W-1:0]      e1, e2;
    logic                             lh1, lh2;
    logic [1:0]                       res_cnt;
    u8dec_pkg::result_t               r0, r1;
    logic [1:0]                       q_cnt;
    logic [1:0]                       keep_cnt;
    logic                             pop;
    logic                             fire;

    assign b          = in_byte_reg;
    assign lead_ascii = (b[7] == 1'b0);
    assign lead_bad   = (b[7:6] == 2'b10) || (b[7:3] == 5'b11111);
    assign is_cont    = (b[7:6] == 2'b10);
    assign acc        = {partial_reg[u8dec_pkg::CP_W-7:0], b[5:0]};
    assign seen_inc   = seen_reg + 3'd1;

    always_comb
    begin
        unique case (seq_len_reg)
            u8dec_pkg::LEN_TWO:   seq_ok = (acc >= u8dec_pkg::MIN_TWO);
            u8dec_pkg::LEN_THREE: seq_ok = (acc > u8dec_pkg::MAX_TWO)
                                        && ((acc < u8dec_pkg::SUR_LO)
                                        || (acc > u8dec_pkg::SUR_HI));
            default:              seq_ok = (acc > u8dec_pkg::MAX_THREE)
                                        && (acc <= u8dec_pkg::MAX_UNI);
        endcase
    end

    // Count results one after another, saturating.
    assign e1  = (emitted_reg == u8dec_pkg::CNT_SAT) ? emitted_reg : emitted_reg + 16'd1;
    assign lh1 = (limit_reg != '0) && (e1 >= limit_reg);
    assign e2  = (e1 == u8dec_pkg::CNT_SAT) ? e1 : e1 + 16'd1;
    assign lh2 = (limit_reg != '0) && (e2 >= limit_reg);

    always_comb
    begin
        res_cnt      = 2'd0;
        r0           = '{code_point: u8dec_pkg::REPL_CP, is_error: 1'b1, last_of_run: 1'b1};
        r1           = '{code_point: u8dec_pkg::REPL_CP, is_error: 1'b1, last_of_run: 1'b1};
        seq_len_next = seq_len_reg;
        seen_next    = seen_reg;
        partial_next = partial_reg;
        emitted_next = emitted_reg;
        lim_hit_next = lim_hit_reg;

        if (b == 8'd0)
        begin
            if (!lim_hit_reg && (seq_len_reg != u8dec_pkg::LEN_NONE))
            begin
                res_cnt = 2'd1;
            end
        end
        else if (lim_hit_reg)
        begin
            res_cnt = 2'd0;
        end
        else if (seq_len_reg != u8dec_pkg::LEN_NONE)
        begin
            if (is_cont)
            begin
                if (seen_inc >= seq_len_reg)
                begin
                    res_cnt         = 2'd1;
                    r0.code_point   = seq_ok ? acc : u8dec_pkg::REPL_CP;
                    r0.is_error     = !seq_ok;
                    seq_len_next    = u8dec_pkg::LEN_NONE;
                    seen_next       = '0;
                    partial_next    = '0;
                end
                else
                begin
                    seen_next    = seen_inc;
                    partial_next = acc;
                end
            end
            else
            begin
                // Flag the broken sequence, then, unless the limit is reached, decode the byte as a new lead.
                res_cnt      = 2'd1;
                r0.last_of_run = 1'b1;
                seq_len_next = u8dec_pkg::LEN_NONE;
                seen_next    = '0;
                partial_next = '0;
                if (!lh1)
                begin
                    if (lead_ascii || lead_bad)
                    begin
                        res_cnt        = 2'd2;
                        r0.last_of_run = 1'b0;
                        r1.code_point  = lead_ascii ? {13'd0, b} : u8dec_pkg::REPL_CP;
                        r1.is_error    = !lead_ascii;
                    end
                    else
                    begin
                        seen_next = 3'd1;
                        if (b[5] == 1'b0)
                        begin
                            seq_len_next = u8dec_pkg::LEN_TWO;
                            partial_next = {16'd0, b[4:0]};
                        end
                        else if (b[4] == 1'b0)
                        begin
                            seq_len_next = u8dec_pkg::LEN_THREE;
                            partial_next = {17'd0, b[3:0]};
                        end
                        else
                        begin
                            seq_len_next = u8dec_pkg::LEN_FOUR;
                            partial_next = {18'd0, b[2:0]};
                        end
                    end
                end
            end
        end
        else
        begin
            if (lead_ascii || lead_bad)
            begin
                res_cnt       = 2'd1;
                r0.code_point = lead_ascii ? {13'd0, b} : u8dec_pkg::REPL_CP;
                r0.is_error   = !lead_ascii;
            end
            else
            begin
                seen_next = 3'd1;
                if (b[5] == 1'b0)
                begin
                    seq_len_next = u8dec_pkg::LEN_TWO;
                    partial_next = {16'd0, b[4:0]};
                end
                else if (b[4] == 1'b0)
                begin
                    seq_len_next = u8dec_pkg::LEN_THREE;
                    partial_next = {17'd0, b[3:0]};
                end
                else
                begin
                    seq_len_next = u8dec_pkg::LEN_FOUR;
                    partial_next = {18'd0, b[2:0]};
                end
            end
        end

        if (res_cnt == 2'd1)
        begin
            emitted_next = e1;
            lim_hit_next = lh1;
        end
        else if (res_cnt == 2'd2)
        begin
            emitted_next = e2;
            lim_hit_next = lh2;
        end

        // Clear the decode state and the result count at the terminator.
        if (b == 8'd0)
        begin
            seq_len_next = u8dec_pkg::LEN_NONE;
            seen_next    = '0;
            partial_next = '0;
            emitted_next = '0;
            lim_hit_next = 1'b0;
        end
    end

    assign q_cnt    = {1'b0, q0_valid_reg} + {1'b0, q1_valid_reg};
    assign pop      = q0_valid_reg && m_axis_tready;
    assign keep_cnt = q_cnt - {1'b0, pop};
    assign fire     = in_valid_reg && (({1'b0, q_cnt} + {1'b0, res_cnt}) <= 3'd2);

    always_comb
    begin
        q0_next       = pop ? q1_reg : q0_reg;
        q1_next       = q1_reg;
        q0_valid_next = (keep_cnt != 2'd0);
        q1_valid_next = (keep_cnt == 2'd2);
        if (fire && (res_cnt != 2'd0))
        begin
            if (keep_cnt == 2'd0)
            begin
                q0_next       = r0;
                q0_valid_next = 1'b1;
            end
            else
            begin
                q1_next       = r0;
                q1_valid_next = 1'b1;
            end
            if (res_cnt == 2'd2)
            begin
                q1_next       = r1;
                q1_valid_next = 1'b1;
            end
        end
    end

    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
            limit_reg    <= '0;
            seq_len_reg  <= u8dec_pkg::LEN_NONE;
            seen_reg     <= '0;
            partial_reg  <= '0;
            emitted_reg  <= '0;
            lim_hit_reg  <= 1'b0;
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                in_byte_reg  <= s_axis_tdata;
            end
            if (fire)
            begin
                seq_len_reg <= seq_len_next;
                seen_reg    <= seen_next;
                partial_reg <= partial_next;
                emitted_reg <= emitted_next;
                lim_hit_reg <= lim_hit_next;
            end
            q0_valid_reg <= q0_valid_next;
            q1_valid_reg <= q1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_axis_tvalid = q0_valid_reg;
    assign m_axis_tdata  = {3'd0, q0_reg.code_point};
    assign m_axis_tuser  = q0_reg.is_error;
    assign m_axis_tlast  = q0_reg.last_of_run;

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        q1_valid_reg |-> q0_valid_reg)
        else $error("second result slot valid while head slot empty");

    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg != u8dec_pkg::LEN_NONE) |-> (seen_reg >= 3'd1) && (seen_reg < seq_len_reg))
        else $error("byte count of open sequence out of range");

    a_limit_closed: assert property (@(posedge clk) disable iff (!rst_n)
        lim_hit_reg |-> (seq_len_reg == u8dec_pkg::LEN_NONE))
        else $error("sequence open after limit reached");

    a_error_repl: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[20:0] == u8dec_pkg::REPL_CP))
        else $error("error result without replacement code point");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the UTF-8 stream decoder: byte stimulus, code point checks.
module testbench;

    class u8dec_scoreboard;
        logic [u8dec_pkg::CNT_W-1:0] cp_limit;
        logic [u8dec_pkg::LEN_W-1:0] open_len;
        logic [u8dec_pkg::LEN_W-1:0] got_len;
        logic [u8dec_pkg::CP_W-1:0]  acc_value;
        logic [u8dec_pkg::CNT_W-1:0] cp_count;
        bit                          capped;
        u8dec_pkg::result_t          cp_queue[$];
        u8dec_pkg::result_t          byte_results[$];
        int                          errors;

        function new();
            cp_limit = '0;
            open_len = u8dec_pkg::LEN_NONE;
            got_len = '0;
            acc_value = '0;
            cp_count = '0;
            capped = 1'b0;
            errors = 0;
        endfunction

        function void set_limit(logic [u8dec_pkg::CNT_W-1:0] value);
            cp_limit = value;
        endfunction

        function void emit_cp(logic [u8dec_pkg::CP_W-1:0] cp, bit err);
            u8dec_pkg::result_t r;
            if (capped || byte_results.size() >= 2)
                return;
            r.code_point = cp;
            r.is_error = err;
            r.last_of_run = 1'b0;
            byte_results.push_back(r);
            if (cp_count != u8dec_pkg::CNT_SAT)
                cp_count++;
            if (cp_limit != '0 && cp_count >= cp_limit)
                capped = 1'b1;
        endfunction

        function void close_seq();
            open_len = u8dec_pkg::LEN_NONE;
            got_len = '0;
            acc_value = '0;
        endfunction

        function void decode_lead(logic [u8dec_pkg::BYTE_W-1:0] b);
            if (b < 8'h80)
                emit_cp(u8dec_pkg::CP_W'(b), 1'b0);
            else if (b < 8'hC0 || b >= 8'hF8)
                emit_cp(u8dec_pkg::REPL_CP, 1'b1);
            else if (b < 8'hE0)
            begin
                open_len = u8dec_pkg::LEN_TWO;
                got_len = 3'd1;
                acc_value = u8dec_pkg::CP_W'(b[4:0]);
            end
            else if (b < 8'hF0)
            begin
                open_len = u8dec_pkg::LEN_THREE;
                got_len = 3'd1;
                acc_value = u8dec_pkg::CP_W'(b[3:0]);
            end
            else
            begin
                open_len = u8dec_pkg::LEN_FOUR;
                got_len = 3'd1;
                acc_value = u8dec_pkg::CP_W'(b[2:0]);
            end
        endfunction

        function void finish_seq();
            logic [u8dec_pkg::CP_W-1:0] v;
            bit ok;
            v = acc_value;
            if (open_len == u8dec_pkg::LEN_TWO)
                ok = v >= u8dec_pkg::MIN_TWO;
            else if (open_len == u8dec_pkg::LEN_THREE)
                ok = v > u8dec_pkg::MAX_TWO && (v < u8dec_pkg::SUR_LO || v > u8dec_pkg::SUR_HI);
            else
                ok = v > u8dec_pkg::MAX_THREE && v <= u8dec_pkg::MAX_UNI;
            close_seq();
            if (ok)
                emit_cp(v, 1'b0);
            else
                emit_cp(u8dec_pkg::REPL_CP, 1'b1);
        endfunction

        function void note_byte(logic [u8dec_pkg::BYTE_W-1:0] b);
            byte_results.delete();
            if (b == '0)
            begin
                if (!capped && open_len != u8dec_pkg::LEN_NONE)
                    emit_cp(u8dec_pkg::REPL_CP, 1'b1);
                close_seq();
                cp_count = '0;
                capped = 1'b0;
            end
            else if (capped)
            begin
            end
            else if (open_len != u8dec_pkg::LEN_NONE)
            begin
                if (b[7:6] == 2'b10)
                begin
                    acc_value = {acc_value[u8dec_pkg::CP_W-7:0], b[5:0]};
                    got_len = got_len + 3'd1;
                    if (got_len >= open_len)
                        finish_seq();
                end
                else
                begin
                    close_seq();
                    emit_cp(u8dec_pkg::REPL_CP, 1'b1);
                    if (!capped)
                        decode_lead(b);
                end
            end
            else
                decode_lead(b);
            if (byte_results.size() > 0)
                byte_results[byte_results.size()-1].last_of_run = 1'b1;
            foreach (byte_results[i])
                cp_queue.push_back(byte_results[i]);
        endfunction

        function void check_cp(u8dec_pkg::result_t got);
            u8dec_pkg::result_t exp;
            if (cp_queue.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual cp %h err %b last %b",
                         $time, got.code_point, got.is_error, got.last_of_run);
                errors++;
                return;
            end
            exp = cp_queue.pop_front();
            if (got.code_point !== exp.code_point)
            begin
                $display("%0t code_point mismatch: expected %h, actual %h",
                         $time, exp.code_point, got.code_point);
                errors++;
            end
            if (got.is_error !== exp.is_error)
            begin
                $display("%0t is_error mismatch: expected %b, actual %b",
                         $time, exp.is_error, got.is_error);
                errors++;
            end
            if (got.last_of_run !== exp.last_of_run)
            begin
                $display("%0t last_of_run mismatch: expected %b, actual %b",
                         $time, exp.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 8;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [u8dec_pkg::BYTE_W-1:0]   s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [u8dec_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           cfg_we;
    logic [u8dec_pkg::CNT_W-1:0]    cfg_wdata;

    u8dec_scoreboard                sb;
    logic [u8dec_pkg::BYTE_W-1:0]   byte_stream[$];
    int                             send_idle_pct;
    int                             recv_idle_pct;
    int                             hold_left;

    utf8_stream_decoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        u8dec_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.code_point = m_axis_tdata[u8dec_pkg::CP_W-1:0];
            got.is_error = m_axis_tuser;
            got.last_of_run = m_axis_tlast;
            sb.check_cp(got);
        end
    end

    function automatic void put_seq(logic [u8dec_pkg::CP_W-1:0] cp, int len, int keep);
        logic [u8dec_pkg::BYTE_W-1:0] b [4];
        case (len)
            1: b[0] = cp[7:0];
            2:
            begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            byte_stream.push_back(b[i]);
    endfunction

    function automatic void put_char();
        int pick;
        int len;
        logic [u8dec_pkg::CP_W-1:0] cp;
        pick = $urandom_range(99);
        if (pick < 40)
            put_seq(u8dec_pkg::CP_W'($urandom_range(1, 127)), 1, 1);
        else if (pick < 55)
            put_seq(u8dec_pkg::CP_W'($urandom_range(12'h080, 12'h7FF)), 2, 2);
        else if (pick < 70)
        begin
            cp = u8dec_pkg::CP_W'($urandom_range(16'h0800, 16'hFFFF));
            if (cp >= u8dec_pkg::SUR_LO && cp <= u8dec_pkg::SUR_HI)
                cp = cp ^ 21'h004000;
            put_seq(cp, 3, 3);
        end
        else if (pick < 80)
            put_seq(u8dec_pkg::CP_W'($urandom_range(21'h010000, 21'h10FFFF)), 4, 4);
        else
        begin
            case ($urandom_range(0, 6))
                0: byte_stream.push_back(u8dec_pkg::BYTE_W'($urandom_range(8'h80, 8'hBF)));
                1: byte_stream.push_back(u8dec_pkg::BYTE_W'($urandom_range(8'hF8, 8'hFF)));
                2:
                begin
                    len = $urandom_range(2, 4);
                    if (len == 2)
                        cp = u8dec_pkg::CP_W'($urandom_range(0, 8'h7F));
                    else if (len == 3)
                        cp = u8dec_pkg::CP_W'($urandom_range(0, 12'h7FF));
                    else
                        cp = u8dec_pkg::CP_W'($urandom_range(0, 16'hFFFF));
                    put_seq(cp, len, len);
                end
                3: put_seq(u8dec_pkg::CP_W'($urandom_range(16'hD800, 16'hDFFF)), 3, 3);
                4: put_seq(u8dec_pkg::CP_W'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
                5:
                begin
                    len = $urandom_range(2, 4);
                    put_seq(u8dec_pkg::CP_W'($urandom_range(21'h000080, 21'h10FFFF)), len,
                            $urandom_range(1, len - 1));
                end
                default: byte_stream.push_back(u8dec_pkg::BYTE_W'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void put_string();
        int n;
        n = $urandom_range(0, 7);
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                byte_stream.push_back(u8dec_pkg::BYTE_W'($urandom_range(1, 255)));
        end
        else
        begin
            repeat (n)
                put_char();
        end
        byte_stream.push_back('0);
    endfunction

    task automatic send_byte(logic [u8dec_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_stream();
        foreach (byte_stream[i])
            send_byte(byte_stream[i]);
        s_axis_tvalid <= 1'b0;
        byte_stream.delete();
    endtask

    task automatic wait_idle();
        while (sb.cp_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_limit(logic [u8dec_pkg::CNT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic run_random(logic [u8dec_pkg::CNT_W-1:0] limit, int n, bit squeeze);
        wait_idle();
        write_limit(limit);
        while (byte_stream.size() < n)
            put_string();
        while (byte_stream.size() > n)
            void'(byte_stream.pop_back());
        if (squeeze)
            hold_left = 300;
        send_stream();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_left = 0;
        send_idle_pct = 26;
        recv_idle_pct = 54;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_limit(16'd0);
        byte_stream = '{8'h41, 8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF,
                        8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                        8'hC3, 8'h41, 8'hE2, 8'h00, 8'h7F, 8'h42, 8'h43};
        send_stream();
        wait_idle();
        write_limit(16'd2);
        byte_stream = '{8'h44, 8'h45, 8'h00, 8'h41, 8'hC3, 8'h42, 8'h43, 8'h00};
        send_stream();

        run_random(16'd0, 200, 1'b0);

        send_idle_pct = 54;
        recv_idle_pct = 26;
        run_random(16'hFFFF, 200, 1'b0);
        run_random(16'd1, 120, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(u8dec_pkg::CNT_W'($urandom_range(2, 4)), 130, 1'b0);
        run_random(16'd0, 150, 1'b1);

        wait_idle();
        if (sb.errors == 0 && sb.cp_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### utf8_stream_decoder.f
design/u8dec_pkg.sv
design/utf8_stream_decoder.sv
tb/sv/testbench.sv
